// File: rtl/core/olid_pkg.sv
package olid_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COUNT_W = 5;

    // command codes, only bit 1 selects list
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        RES_DONE     = 3'd0,
        RES_EMPTY    = 3'd1,
        RES_NOTFOUND = 3'd2,
        RES_FULL     = 3'd3,
        RES_ENTRY    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_EMIT,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    do_insert;
        logic    clr_pos;
        logic    inc_pos;
        logic    rd_next;
        logic    shift_we;
        logic    dec_count;
        logic    out_load;
        t_status out_status;
        logic    out_entry;
        logic    out_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cmd_list;
        logic cmd_insert;
        logic empty;
        logic full;
        logic match;
        logic at_last;
        logic shift_end;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/olid_cmd_if.sv
interface olid_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [olid_pkg::CMD_W-1:0]   command;
    logic signed [olid_pkg::VALUE_W-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

// File: rtl/core/olid_res_if.sv
interface olid_res_if;
    logic                                valid;
    logic                                ready;
    logic        [olid_pkg::STAT_W-1:0]  status;
    logic signed [olid_pkg::VALUE_W-1:0] entry_value;
    logic        [olid_pkg::COUNT_W-1:0] entry_count;
    logic                                last;

    modport source (output valid, output status, output entry_value, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_value, input entry_count,
                    input last, output ready);
endinterface

// File: rtl/core/ordered_list_insert_delete.sv
// flow: one request at a time, next request taken once the last result is in the output
//   register; a delete searches from the head and, on a hit, shifts the entries behind
//   it; a list reads each entry in turn; the ring store has a registered read, and a
//   stalled output holds the block until the result is taken
// reset: synchronous active-low i_rst_n empties the list and drops any pending result;
module ordered_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    olid_cmd_if.sink      i_cmd,
    olid_res_if.source    o_res
);

    // entries live in a ring buffer: head moves back on insert, a delete closes the
    // gap by moving the entries behind the match one place toward the head
    // store contents are not cleared on reset, entries beyond the fill count are never used

    olid_pkg::t_dp_cmd    dp_cmd;
    olid_pkg::t_dp_status dp_status;
    logic                 in_ready;

    assign i_cmd.ready = in_ready;

    // sequencer: accepts a request, walks search, shift or list steps
    olid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // store, head pointer, fill count, compare and output register
    olid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_command    (i_cmd.command),
        .i_item_value (i_cmd.item_value),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_out_status (o_res.status),
        .o_out_value  (o_res.entry_value),
        .o_out_count  (o_res.entry_count),
        .o_out_last   (o_res.last)
    );

endmodule

// File: rtl/core/olid_ram.sv
module olid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/olid_ctrl.sv
module olid_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  olid_pkg::t_dp_status i_status,
    output olid_pkg::t_dp_cmd    o_cmd
);

    olid_pkg::t_state  r_state, n_state;
    olid_pkg::t_status r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pend <= n_pend;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        case (r_state)
            olid_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = olid_pkg::S_DISPATCH;
                end
            end
            olid_pkg::S_DISPATCH: begin
                if (i_status.cmd_list) begin
                    if (i_status.empty) begin
                        n_state = olid_pkg::S_EMIT;
                        n_pend  = olid_pkg::RES_EMPTY;
                    end else begin
                        n_state = olid_pkg::S_LIST_RD;
                    end
                end else if (i_status.cmd_insert) begin
                    n_state = olid_pkg::S_EMIT;
                    n_pend  = i_status.full ? olid_pkg::RES_FULL : olid_pkg::RES_DONE;
                end else if (i_status.empty) begin
                    n_state = olid_pkg::S_EMIT;
                    n_pend  = olid_pkg::RES_EMPTY;
                end else begin
                    n_state = olid_pkg::S_SRCH_RD;
                end
            end
            olid_pkg::S_SRCH_RD: begin
                n_state = olid_pkg::S_SRCH_CHK;
            end
            olid_pkg::S_SRCH_CHK: begin
                if (i_status.match) begin
                    n_state = olid_pkg::S_SHIFT_RD;
                end else if (i_status.at_last) begin
                    n_state = olid_pkg::S_EMIT;
                    n_pend  = olid_pkg::RES_NOTFOUND;
                end else begin
                    n_state = olid_pkg::S_SRCH_RD;
                end
            end
            olid_pkg::S_SHIFT_RD: begin
                if (i_status.shift_end) begin
                    n_state = olid_pkg::S_EMIT;
                    n_pend  = olid_pkg::RES_DONE;
                end else begin
                    n_state = olid_pkg::S_SHIFT_WR;
                end
            end
            olid_pkg::S_SHIFT_WR: begin
                n_state = olid_pkg::S_SHIFT_RD;
            end
            olid_pkg::S_LIST_RD: begin
                n_state = olid_pkg::S_LIST_EMIT;
            end
            olid_pkg::S_LIST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.at_last ? olid_pkg::S_IDLE : olid_pkg::S_LIST_RD;
                end
            end
            olid_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = olid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olid_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.out_status = olid_pkg::RES_DONE;
        case (r_state)
            olid_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            olid_pkg::S_DISPATCH: begin
                o_cmd.clr_pos   = 1'b1;
                o_cmd.do_insert = !i_status.cmd_list && i_status.cmd_insert && !i_status.full;
            end
            olid_pkg::S_SRCH_CHK: begin
                o_cmd.inc_pos = !i_status.match && !i_status.at_last;
            end
            olid_pkg::S_SHIFT_RD: begin
                o_cmd.rd_next   = 1'b1;
                o_cmd.dec_count = i_status.shift_end;
            end
            olid_pkg::S_SHIFT_WR: begin
                o_cmd.rd_next  = 1'b1;
                o_cmd.shift_we = 1'b1;
                o_cmd.inc_pos  = 1'b1;
            end
            olid_pkg::S_LIST_EMIT: begin
                o_cmd.out_load   = i_status.out_free;
                o_cmd.out_status = olid_pkg::RES_ENTRY;
                o_cmd.out_entry  = 1'b1;
                o_cmd.out_last   = i_status.at_last;
                o_cmd.inc_pos    = i_status.out_free && !i_status.at_last;
            end
            olid_pkg::S_EMIT: begin
                o_cmd.out_load   = i_status.out_free;
                o_cmd.out_status = r_pend;
                o_cmd.out_last   = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/olid_datapath.sv
module olid_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic        [olid_pkg::CMD_W-1:0]   i_command,
    input  logic signed [olid_pkg::VALUE_W-1:0] i_item_value,
    input  olid_pkg::t_dp_cmd                   i_cmd,
    output olid_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic        [olid_pkg::STAT_W-1:0]  o_out_status,
    output logic signed [olid_pkg::VALUE_W-1:0] o_out_value,
    output logic        [olid_pkg::COUNT_W-1:0] o_out_count,
    output logic                                o_out_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_X = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] TOP   = AW'(CAPACITY - 1);

    logic        [olid_pkg::CMD_W-1:0]   r_cmd;
    logic signed [olid_pkg::VALUE_W-1:0] r_value;
    logic        [AW-1:0]                r_head;
    logic        [CW-1:0]                r_count;
    logic        [AW-1:0]                r_pos;

    logic                                r_out_valid;
    olid_pkg::t_status                   r_out_status;
    logic signed [olid_pkg::VALUE_W-1:0] r_out_value;
    logic        [CW-1:0]                r_out_count;
    logic                                r_out_last;

    logic [AW-1:0]                head_dec;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                pos_addr;
    logic [AW-1:0]                wr_addr;
    logic [olid_pkg::VALUE_W-1:0] wr_data;
    logic [olid_pkg::VALUE_W-1:0] rd_data;
    logic                         we;
    logic [CW-1:0]                pos_ext;

    // logical position to ring address
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                               input logic [AW-1:0] pos,
                                               input logic          off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos} + (AW + 1)'(off);
        if (sum >= CAP_X) begin
            sum = sum - CAP_X;
        end
        return sum[AW-1:0];
    endfunction

    assign head_dec = (r_head == '0) ? TOP : r_head - AW'(1);
    assign rd_addr  = ring_addr(r_head, r_pos, i_cmd.rd_next);
    assign pos_addr = ring_addr(r_head, r_pos, 1'b0);
    assign wr_addr  = i_cmd.do_insert ? head_dec : pos_addr;
    assign wr_data  = i_cmd.do_insert ? r_value : rd_data;
    assign we       = i_cmd.do_insert || i_cmd.shift_we;
    assign pos_ext  = CW'(r_pos);

    olid_ram #(
        .WIDTH (olid_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_insert) begin
                r_head  <= head_dec;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_value <= i_item_value;
        end
        if (i_cmd.clr_pos) begin
            r_pos <= '0;
        end else if (i_cmd.inc_pos) begin
            r_pos <= r_pos + AW'(1);
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_value  <= i_cmd.out_entry ? $signed(rd_data) : '0;
            r_out_count  <= r_count;
            r_out_last   <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_status.cmd_list   = r_cmd[1];
        o_status.cmd_insert = (r_cmd == olid_pkg::CMD_INSERT);
        o_status.empty      = (r_count == '0);
        o_status.full       = (r_count == CW'(CAPACITY));
        o_status.match      = (rd_data == r_value);
        o_status.at_last    = (pos_ext + CW'(1) == r_count);
        o_status.shift_end  = (pos_ext + CW'(1) == r_count);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_value  = r_out_value;
    assign o_out_count  = olid_pkg::COUNT_W'(r_out_count);
    assign o_out_last   = r_out_last;

endmodule

// File: tb/tb_ordered_list_insert_delete.sv
module tb_ordered_list_insert_delete;
    import olid_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 352;
    localparam int HOLD_CYCLES  = 300;
    // a delete may scan and shift across the whole list; the drain is sized from the list depth
    localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // only bit 1 of the command is decoded, so code 3 is a second list code
    localparam logic [CMD_W-1:0] CMD_LIST_ALT = 2'd3;

    // one result as seen on the output channel
    typedef struct packed {
        t_status                     status;
        logic signed [VALUE_W-1:0]   value;
        logic        [COUNT_W-1:0]   count;
        logic                        last;
    } result_t;

    // one row of the directed plan; typed rows carry their single result inline
    typedef struct {
        logic        [CMD_W-1:0]     cmd;
        logic signed [VALUE_W-1:0]   value;
        int                          reps;
        bit                          typed;
        t_status                     status;
        logic        [COUNT_W-1:0]   count;
    } plan_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #4 i_clk = ~i_clk;

    olid_cmd_if cmd_if ();
    olid_res_if res_if ();

    ordered_list_insert_delete #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // mirror of the list contents, head at index 0
    logic signed [VALUE_W-1:0] held_entries[$];
    // results still owed by the block, oldest first
    result_t                   pending_results[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    bit  hold_request   = 1'b0;

    function automatic result_t make_result(t_status st, logic signed [VALUE_W-1:0] v,
                                            logic [COUNT_W-1:0] c, logic l);
        result_t r;
        r.status = st;
        r.value  = v;
        r.count  = c;
        r.last   = l;
        return r;
    endfunction

    // apply one accepted request to the mirror and queue the results it owes
    function automatic void predict_list_results(logic [CMD_W-1:0] cmd,
                                                 logic signed [VALUE_W-1:0] val);
        int      hit;
        int      n;
        t_status st;
        hit = -1;
        n   = held_entries.size();
        if (cmd[1]) begin
            // list: every entry head to tail, or a single empty marker
            if (n == 0) begin
                pending_results.push_back(make_result(RES_EMPTY, '0, '0, 1'b1));
            end else begin
                for (int i = 0; i < n; i++)
                    pending_results.push_back(make_result(RES_ENTRY, held_entries[i],
                                                          COUNT_W'(n), (i == n - 1)));
            end
        end else begin
            if (cmd == CMD_INSERT) begin
                if (n >= LIST_DEPTH) begin
                    st = RES_FULL;
                end else begin
                    held_entries.push_front(val);
                    st = RES_DONE;
                end
            end else if (n == 0) begin
                st = RES_EMPTY;
            end else begin
                // first match counted from the head
                for (int i = 0; i < n; i++) begin
                    if (hit < 0 && held_entries[i] == val)
                        hit = i;
                end
                if (hit < 0) begin
                    st = RES_NOTFOUND;
                end else begin
                    held_entries.delete(hit);
                    st = RES_DONE;
                end
            end
            pending_results.push_back(make_result(st, '0, COUNT_W'(held_entries.size()), 1'b1));
        end
    endfunction

    function automatic void note_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch (%s): expected status %0d value %0d count %0d last %0b, %s",
                     what, want.status, want.value, want.count, want.last,
                     $sformatf("got status %0d value %0d count %0d last %0b",
                               got.status, got.value, got.count, got.last));
    endfunction

    // request driver: bursts of back-to-back requests split by random idle gaps
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [VALUE_W-1:0] val,
                                input bit typed, input result_t typed_res);
        int gap;
        int mark;
        if (burst_left == 0) begin
            // some bursts run straight on from the previous one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= cmd;
        cmd_if.item_value <= val;
        do @(posedge i_clk); while (!cmd_if.ready);
        burst_left--;
        // the mirror always advances; typed rows swap in their written-down result
        mark = pending_results.size();
        predict_list_results(cmd, val);
        if (typed) begin
            while (pending_results.size() > mark)
                void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
    endtask

    // value mix: extremes, a narrow band that yields duplicates, and full range
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2: v = $urandom_range(0, 8) - 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // result receiver: own stall pattern, switched to a new random mode whenever one runs out,
    // plus one long hold-off so the block backs up and drops cmd ready
    initial begin
        int mode;
        int mode_left;
        int stall_left;
        int phase;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        phase      = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            if (hold_request && stall_left == 0) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    2: begin
                        // occasional stall runs of random length
                        if ($urandom_range(0, 5) == 0) begin
                            stall_left   = $urandom_range(0, 7);
                            res_if.ready <= 1'b0;
                        end else begin
                            res_if.ready <= 1'b1;
                        end
                    end
                    default: res_if.ready <= phase[0];
                endcase
            end
        end
    end

    // result checker: each accepted result against the oldest one owed
    always @(posedge i_clk) begin
        result_t seen;
        result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen = make_result(t_status'(res_if.status), res_if.entry_value,
                               res_if.entry_count, res_if.last);
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing outstanding", '0, seen);
            end else begin
                want = pending_results.pop_front();
                if (seen.status !== want.status || seen.value !== want.value ||
                    seen.count !== want.count || seen.last !== want.last)
                    note_mismatch("field", want, seen);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ordered_list_insert_delete: done, errors");
            $finish;
        end
    end

    // directed plan: empty cases, extremes, duplicates, fill to full, refusal
    plan_row_t directed_plan [16] = '{
        '{CMD_LIST,     32'sh5a5a_5a5a, 1,  1'b1, RES_EMPTY,    5'd0},
        '{CMD_DELETE,   32'sh0000_0000, 1,  1'b1, RES_EMPTY,    5'd0},
        '{CMD_INSERT,   32'sh7fff_ffff, 1,  1'b1, RES_DONE,     5'd1},
        '{CMD_INSERT,   32'sh8000_0000, 1,  1'b1, RES_DONE,     5'd2},
        '{CMD_LIST,     32'sha5a5_a5a5, 1,  1'b0, RES_DONE,     5'd0},
        '{CMD_DELETE,   32'sh0000_0005, 1,  1'b1, RES_NOTFOUND, 5'd2},
        '{CMD_INSERT,   32'shffff_ffff, 1,  1'b1, RES_DONE,     5'd3},
        '{CMD_INSERT,   32'sh0000_0000, 1,  1'b1, RES_DONE,     5'd4},
        '{CMD_INSERT,   32'shffff_ffff, 1,  1'b1, RES_DONE,     5'd5},
        '{CMD_LIST_ALT, 32'shffff_ffff, 1,  1'b0, RES_DONE,     5'd0},
        '{CMD_DELETE,   32'shffff_ffff, 1,  1'b1, RES_DONE,     5'd4},
        '{CMD_DELETE,   32'sh7fff_ffff, 1,  1'b1, RES_DONE,     5'd3},
        '{CMD_INSERT,   32'sh5555_5555, 13, 1'b0, RES_DONE,     5'd0},
        '{CMD_INSERT,   32'shaaaa_aaaa, 1,  1'b1, RES_FULL,     5'd16},
        '{CMD_LIST,     32'sh0000_0000, 1,  1'b0, RES_DONE,     5'd0},
        '{CMD_DELETE,   32'sh1234_5678, 1,  1'b1, RES_NOTFOUND, 5'd16}
    };

    initial begin
        logic        [CMD_W-1:0]   cmd;
        logic signed [VALUE_W-1:0] val;
        bit                        filling;
        int                        pick;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_INSERT;
        cmd_if.item_value = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r])
            repeat (directed_plan[r].reps)
                send_request(directed_plan[r].cmd, directed_plan[r].value, directed_plan[r].typed,
                             make_result(directed_plan[r].status, '0, directed_plan[r].count, 1'b1));

        // random part: swing the list between empty and full so every size is
        // visited, with lists throughout and deletes mostly aimed at held values
        filling = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // early on, park the receiver long enough for requests to back up
            if (n == 40)
                hold_request = 1'b1;
            if (held_entries.size() >= LIST_DEPTH)
                filling = 1'b0;
            else if (held_entries.size() == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;

            pick = $urandom_range(0, 99);
            if (pick < 5)
                cmd = CMD_LIST_ALT;
            else if (pick < 20)
                cmd = CMD_LIST;
            else if (filling ? (pick < 75) : (pick < 35))
                cmd = CMD_INSERT;
            else
                cmd = CMD_DELETE;

            if (cmd == CMD_DELETE && held_entries.size() > 0 && $urandom_range(0, 9) < 7)
                val = held_entries[$urandom_range(0, held_entries.size() - 1)];
            else if (cmd[1])
                val = $urandom;
            else
                val = pick_value();

            send_request(cmd, val, 1'b0, '0);
        end
        cmd_if.valid <= 1'b0;

        // wait out everything owed, then a quiet stretch for stray results
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_ordered_list_insert_delete: done, clean");
        end else begin
            $display("tb_ordered_list_insert_delete: done, errors");
        end
        $finish;
    end

endmodule
